[rtl/plti_pkg.sv]
package plti_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_KNOT  = 2'd0,
    MODE_ROW   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_KNOT_COUNT = 2'd0,
    CFG_ROW_LENGTH = 2'd1,
    CFG_HOLD_MODE  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD0,
    ST_LDN,
    ST_CHK,
    ST_SRCH,
    ST_DIV,
    ST_DIVW,
    ST_RDA,
    ST_RDB,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_OUT,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [5:0]        knot_index;
    logic [3:0]        element_index;
    logic signed [31:0] time_value;
    logic signed [31:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         element_index_res;
    logic signed [31:0] value;
    logic               last;
    logic               out_of_range;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

[rtl/plti_div.sv]
module plti_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);

  logic        running_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [31:0] quot_r;
  logic [32:0] rem2;
  logic        ge;
  logic [31:0] rem_nxt;

  // The numerator is below the divisor, so each step keeps the remainder in 32 bits.
  always_comb begin
    rem2    = {rem_r, 1'b0};
    ge      = rem2 >= {1'b0, den_r};
    rem_nxt = ge ? 32'(rem2 - {1'b0, den_r}) : rem2[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        running_r <= 1'b1;
        cnt_r     <= '0;
      end else if (running_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          running_r <= 1'b0;
          done_r    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
    end else if (running_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[30:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[rtl/plti_mul.sv]
module plti_mul (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [15:0] b,
  output logic [48:0] p
);

  logic [48:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= 49'(a) * 49'(b);
  end

  assign p = p_r;

endmodule

[rtl/piecewise_linear_table_interp.sv]
// Table writes and unused modes are taken in the idle state. A query runs a bounds check, a
// knot-by-knot segment search and, in interpolation mode, the bit-serial divider; then, for
// each row element, it reads two entries through the single read port of the row memory and,
// in interpolation mode, runs the two-pass 33x16 multiplier. Out-of-range gives an error word.
// One item is in flight at a time. Reset is synchronous and active low; it clears control
// state and loads the registers with 2, 3 and 0; the tables are undefined until written.
module piecewise_linear_table_interp #(
  parameter int MAX_KNOTS = 64,
  parameter int MAX_ROW   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plti_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output plti_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data
);

  localparam int KAW   = $clog2(MAX_KNOTS);
  localparam int RAW   = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int DEPTH = MAX_KNOTS * MAX_ROW;
  localparam int RVW   = $clog2(DEPTH);

  plti_pkg::state_t state_r, state_nxt;

  logic [6:0] knot_count_r;
  logic [4:0] row_length_r;
  logic       hold_mode_r;

  logic [KAW-1:0] nm1_cfg;
  logic [RAW-1:0] rlm1_cfg;
  logic [KAW-1:0] nm1_r;
  logic [RAW-1:0] rlm1_r;
  logic           hold_r;
  logic [31:0]    q_r;
  logic [31:0]    tprev_r;
  logic [31:0]    tlo_r;
  logic [31:0]    thi_r;
  logic [KAW-1:0] i_r;
  logic [KAW-1:0] seg_r;
  logic           direct_r;
  logic [RAW-1:0] j_r;
  logic [31:0]    y1_r;
  logic           neg_r;
  logic [32:0]    mag_r;
  logic [48:0]    plo_r;
  logic [31:0]    res_r;

  logic [31:0] kt_mem [MAX_KNOTS];
  logic [31:0] rv_mem [DEPTH];
  logic [31:0] kt_rd_r;
  logic [31:0] rv_rd_r;

  logic           in_fire;
  logic           kt_we;
  logic           rv_we;
  logic [KAW-1:0] kt_waddr;
  logic [RVW-1:0] rv_waddr;
  logic [KAW-1:0] kt_addr;
  logic [RVW-1:0] rv_addr;
  logic           load_ok;
  logic           seg_hit;
  logic           oor;
  logic [15:0]    mul_b;
  logic [48:0]    mul_p;
  logic [32:0]    dy;
  logic [64:0]    prod_sum;
  logic [31:0]    step;

  plti_pkg::div_ctl_t div_ctl;
  logic [31:0]        div_quot;

  logic                out_valid_r;
  plti_pkg::out_word_t out_word_r;

  assign in_fire = in_valid && in_ready;
  assign load_ok = !out_valid_r || out_ready;
  assign seg_hit = ($signed(tprev_r) <= $signed(q_r)) && ($signed(q_r) < $signed(kt_rd_r));
  assign oor     = ($signed(q_r) < $signed(tprev_r)) || ($signed(q_r) > $signed(kt_rd_r));

  always_comb begin
    if (32'(knot_count_r) >= MAX_KNOTS) begin
      nm1_cfg = KAW'(MAX_KNOTS - 1);
    end else if (knot_count_r < 7'd2) begin
      nm1_cfg = KAW'(1);
    end else begin
      nm1_cfg = KAW'(knot_count_r - 7'd1);
    end
    if (32'(row_length_r) >= MAX_ROW) begin
      rlm1_cfg = RAW'(MAX_ROW - 1);
    end else if (row_length_r == 5'd0) begin
      rlm1_cfg = '0;
    end else begin
      rlm1_cfg = RAW'(row_length_r - 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_count_r <= 7'd2;
      row_length_r <= 5'd3;
      hold_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      case (plti_pkg::cfg_idx_t'(cfg_index))
        plti_pkg::CFG_KNOT_COUNT: knot_count_r <= cfg_data;
        plti_pkg::CFG_ROW_LENGTH: row_length_r <= cfg_data[4:0];
        plti_pkg::CFG_HOLD_MODE:  hold_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign kt_we = in_fire && (in_word.mode == plti_pkg::MODE_KNOT)
                 && (32'(in_word.knot_index) < MAX_KNOTS);
  assign rv_we = in_fire && (in_word.mode == plti_pkg::MODE_ROW)
                 && (32'(in_word.knot_index) < MAX_KNOTS)
                 && (32'(in_word.element_index) < MAX_ROW);
  assign kt_waddr = KAW'(in_word.knot_index);
  assign rv_waddr = RVW'(32'(in_word.knot_index) * MAX_ROW + 32'(in_word.element_index));

  always_ff @(posedge clk) begin
    if (kt_we) begin
      kt_mem[kt_waddr] <= in_word.time_value;
    end
    kt_rd_r <= kt_mem[kt_addr];
  end

  always_ff @(posedge clk) begin
    if (rv_we) begin
      rv_mem[rv_waddr] <= in_word.sample_value;
    end
    rv_rd_r <= rv_mem[rv_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plti_pkg::ST_IDLE: begin
        if (in_fire && (in_word.mode == plti_pkg::MODE_QUERY)) begin
          state_nxt = plti_pkg::ST_LD0;
        end
      end
      plti_pkg::ST_LD0: state_nxt = plti_pkg::ST_LDN;
      plti_pkg::ST_LDN: state_nxt = plti_pkg::ST_CHK;
      plti_pkg::ST_CHK: state_nxt = oor ? plti_pkg::ST_ERR : plti_pkg::ST_SRCH;
      plti_pkg::ST_SRCH: begin
        if (seg_hit) begin
          state_nxt = hold_r ? plti_pkg::ST_RDA : plti_pkg::ST_DIV;
        end else if (i_r == nm1_r) begin
          state_nxt = plti_pkg::ST_RDA;
        end
      end
      plti_pkg::ST_DIV:  state_nxt = plti_pkg::ST_DIVW;
      plti_pkg::ST_DIVW: begin
        if (div_ctl.done) begin
          state_nxt = plti_pkg::ST_RDA;
        end
      end
      plti_pkg::ST_RDA:  state_nxt = plti_pkg::ST_RDB;
      plti_pkg::ST_RDB:  state_nxt = direct_r ? plti_pkg::ST_OUT : plti_pkg::ST_MUL0;
      plti_pkg::ST_MUL0: state_nxt = plti_pkg::ST_MUL1;
      plti_pkg::ST_MUL1: state_nxt = plti_pkg::ST_MUL2;
      plti_pkg::ST_MUL2: state_nxt = plti_pkg::ST_MUL3;
      plti_pkg::ST_MUL3: state_nxt = plti_pkg::ST_OUT;
      plti_pkg::ST_OUT: begin
        if (load_ok) begin
          state_nxt = (j_r == rlm1_r) ? plti_pkg::ST_IDLE : plti_pkg::ST_RDA;
        end
      end
      plti_pkg::ST_ERR: begin
        if (load_ok) begin
          state_nxt = plti_pkg::ST_IDLE;
        end
      end
      default: state_nxt = plti_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    kt_addr       = '0;
    rv_addr       = RVW'(32'(seg_r) * MAX_ROW + 32'(j_r));
    div_ctl.start = 1'b0;
    mul_b         = div_quot[15:0];
    case (state_r)
      plti_pkg::ST_IDLE: in_ready = 1'b1;
      plti_pkg::ST_LDN:  kt_addr  = nm1_r;
      plti_pkg::ST_CHK:  kt_addr  = KAW'(1);
      plti_pkg::ST_SRCH: kt_addr  = KAW'(32'(i_r) + 32'd1);
      plti_pkg::ST_DIV:  div_ctl.start = 1'b1;
      plti_pkg::ST_RDB:  rv_addr = RVW'((32'(seg_r) + 32'd1) * MAX_ROW + 32'(j_r));
      plti_pkg::ST_MUL2: mul_b = div_quot[31:16];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plti_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    dy       = 33'($signed(rv_rd_r)) - 33'($signed(y1_r));
    prod_sum = {mul_p, 16'b0} + 65'(plo_r);
    step     = prod_sum[63:32];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      plti_pkg::ST_IDLE: begin
        if (in_fire) begin
          q_r    <= in_word.time_value;
          nm1_r  <= nm1_cfg;
          rlm1_r <= rlm1_cfg;
          hold_r <= hold_mode_r;
        end
      end
      plti_pkg::ST_LDN: tprev_r <= kt_rd_r;
      plti_pkg::ST_CHK: begin
        i_r <= KAW'(1);
        j_r <= '0;
      end
      plti_pkg::ST_SRCH: begin
        if (seg_hit) begin
          seg_r    <= i_r - KAW'(1);
          direct_r <= hold_r;
          tlo_r    <= tprev_r;
          thi_r    <= kt_rd_r;
        end else if (i_r == nm1_r) begin
          seg_r    <= nm1_r;
          direct_r <= 1'b1;
        end else begin
          tprev_r <= kt_rd_r;
          i_r     <= i_r + KAW'(1);
        end
      end
      plti_pkg::ST_RDB: begin
        y1_r  <= rv_rd_r;
        res_r <= rv_rd_r;
      end
      plti_pkg::ST_MUL0: begin
        neg_r <= dy[32];
        mag_r <= dy[32] ? 33'(-dy) : dy;
      end
      plti_pkg::ST_MUL2: plo_r <= mul_p;
      plti_pkg::ST_MUL3: res_r <= neg_r ? (y1_r - step) : (y1_r + step);
      plti_pkg::ST_OUT: begin
        if (load_ok) begin
          j_r <= j_r + RAW'(1);
        end
      end
      default: ;
    endcase
  end

  plti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_ctl.start),
    .num   (q_r - tlo_r),
    .den   (thi_r - tlo_r),
    .done  (div_ctl.done),
    .quot  (div_quot)
  );

  plti_mul u_mul (
    .clk (clk),
    .a   (mag_r),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_ok && ((state_r == plti_pkg::ST_OUT) || (state_r == plti_pkg::ST_ERR))) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && (state_r == plti_pkg::ST_OUT)) begin
      out_word_r.element_index_res <= 4'(j_r);
      out_word_r.value             <= res_r;
      out_word_r.last              <= (j_r == rlm1_r);
      out_word_r.out_of_range      <= 1'b0;
    end else if (load_ok && (state_r == plti_pkg::ST_ERR)) begin
      out_word_r.element_index_res <= '0;
      out_word_r.value             <= '0;
      out_word_r.last              <= 1'b1;
      out_word_r.out_of_range      <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.done |-> (state_r == plti_pkg::ST_DIVW))
    else $error("divider finished while the sequencer was not waiting for it");

  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_word.mode == plti_pkg::MODE_QUERY)) |=> (!in_ready && (state_r == plti_pkg::ST_LD0)))
    else $error("accepted query did not start the bounds check");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.out_of_range) |->
      (out_word.last && (out_word.value == 32'sd0) && (out_word.element_index_res == 4'd0)))
    else $error("malformed out-of-range word");

endmodule

[dv/piecewise_linear_table_interp_tb.sv]
`timescale 1ns / 1ps
module piecewise_linear_table_interp_tb;
  import plti_pkg::*;

  localparam int KNOTS = 64;
  localparam int ROWS = 16;
  localparam int IDLE_PERCENT = 28;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_WORDS = 180;
  localparam longint T_MIN = -64'sd2147483648;
  localparam longint T_MAX = 64'sd2147483647;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_word;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;

  piecewise_linear_table_interp uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic signed [31:0] knot_time [KNOTS];
  logic signed [31:0] row_val [KNOTS][ROWS];
  bit row_set [KNOTS][ROWS];
  logic [6:0] knot_count_reg = 7'd2;
  logic [4:0] row_length_reg = 5'd3;
  logic hold_reg = 1'b0;

  out_word_t samples_due [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int hold_off_req = 0;
  int hold_off_left = 0;
  bit calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int knots_in_use();
    int n;
    n = knot_count_reg;
    if (n < 2) n = 2;
    if (n > KNOTS) n = KNOTS;
    return n;
  endfunction

  function automatic int row_in_use();
    int rl;
    rl = row_length_reg;
    if (rl < 1) rl = 1;
    if (rl > ROWS) rl = ROWS;
    return rl;
  endfunction

  function automatic logic signed [31:0] lerp_sample(longint y0, longint y1, longint q,
                                                    longint t0, longint t1);
    bit [63:0] dq, dt, frac, mag, step;
    longint dy, r;
    dq = q - t0;
    dt = t1 - t0;
    frac = (dq << 32) / dt;
    dy = y1 - y0;
    mag = (dy < 0) ? -dy : dy;
    step = (mag * frac) >> 32;
    r = (dy < 0) ? y0 - longint'(step) : y0 + longint'(step);
    return r[31:0];
  endfunction

  task automatic predict_samples(input in_word_t w);
    int n, rl, seg;
    bit found;
    longint q, lo_t, hi_t;
    out_word_t r;
    case (w.mode)
      MODE_KNOT: knot_time[w.knot_index] = w.time_value;
      MODE_ROW: begin
        row_val[w.knot_index][w.element_index] = w.sample_value;
        row_set[w.knot_index][w.element_index] = 1'b1;
      end
      MODE_QUERY: begin
        n = knots_in_use();
        rl = row_in_use();
        q = $signed(w.time_value);
        lo_t = knot_time[0];
        hi_t = knot_time[n - 1];
        if (q < lo_t || q > hi_t) begin
          r.element_index_res = '0;
          r.value = '0;
          r.last = 1'b1;
          r.out_of_range = 1'b1;
          samples_due.push_back(r);
        end else begin
          seg = n - 1;
          found = 1'b0;
          for (int i = 0; i + 1 < n && !found; i++) begin
            if (knot_time[i] <= q && q < knot_time[i + 1]) begin
              seg = i;
              found = 1'b1;
            end
          end
          for (int j = 0; j < rl; j++) begin
            r.element_index_res = j[3:0];
            if (!found || hold_reg) begin
              r.value = row_val[seg][j];
            end else begin
              r.value = lerp_sample(row_val[seg][j], row_val[seg + 1][j], q,
                                    knot_time[seg], knot_time[seg + 1]);
            end
            r.last = (j == rl - 1);
            r.out_of_range = 1'b0;
            samples_due.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_word_t word_of(mode_t m, int k, int e, longint t, longint s);
    in_word_t w;
    w.mode = m;
    w.knot_index = k[5:0];
    w.element_index = e[3:0];
    w.time_value = t[31:0];
    w.sample_value = s[31:0];
    return w;
  endfunction

  function automatic longint rand_sample();
    case ($urandom_range(0, 7))
      0: return T_MIN;
      1: return T_MAX;
      2: return 0;
      3: return longint'($urandom_range(0, 2000)) - 1000;
      default: return longint'(int'($urandom));
    endcase
  endfunction

  task automatic send_word(input in_word_t w);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    predict_samples(w);
  endtask

  task automatic put_knot(input int k, input longint t);
    send_word(word_of(MODE_KNOT, k, $urandom, t, $urandom));
  endtask

  task automatic put_sample(input int k, input int e, input longint s);
    send_word(word_of(MODE_ROW, k, e, $urandom, s));
  endtask

  task automatic query(input longint q);
    send_word(word_of(MODE_QUERY, $urandom, $urandom, q, $urandom));
  endtask

  task automatic query_inside();
    int n;
    longint lo_t, hi_t;
    n = knots_in_use();
    lo_t = knot_time[0];
    hi_t = knot_time[n - 1];
    if (hi_t >= lo_t) query(lo_t + longint'($urandom_range(0, 32'(hi_t - lo_t))));
    else query(longint'(int'($urandom)));
  endtask

  task automatic query_edge();
    int k;
    k = $urandom_range(0, knots_in_use() - 1);
    case ($urandom_range(0, 5))
      0: query(knot_time[k]);
      1: query(knot_time[k] - 1);
      2: query(knot_time[k] + 1);
      3: query(knot_time[0] - 1);
      4: query(knot_time[knots_in_use() - 1] + 1);
      default: query(longint'(int'($urandom)));
    endcase
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [6:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    case (idx)
      CFG_KNOT_COUNT: knot_count_reg = d;
      CFG_ROW_LENGTH: row_length_reg = d[4:0];
      CFG_HOLD_MODE: hold_reg = d[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [6:0] kc, input logic [6:0] rl,
                            input logic [6:0] hold_bit);
    quiesce();
    put_reg(CFG_KNOT_COUNT, kc);
    put_reg(CFG_ROW_LENGTH, rl);
    put_reg(CFG_HOLD_MODE, hold_bit);
    cfg_we <= 1'b0;
  endtask

  // Writes a strictly increasing set of knot times and fills every row entry in use.
  task automatic prepare_table(input int kind);
    int n, rl;
    longint lo, hi, span, gap, t;
    n = knots_in_use();
    rl = row_in_use();
    span = (kind == 1) ? longint'($urandom_range(n - 1, 1 << 24)) : longint'(n - 1);
    lo = T_MIN + longint'($urandom_range(0, 32'(T_MAX - T_MIN - span)));
    hi = lo + span;
    if (kind == 0) begin
      lo = T_MIN;
      hi = T_MAX;
    end
    gap = (hi - lo) / (n - 1);
    for (int k = 0; k < n; k++) begin
      t = lo + (hi - lo) * k / (n - 1);
      if (k > 0 && k < n - 1 && gap >= 4) t += longint'($urandom_range(0, 32'(gap / 2 - 1)));
      put_knot(k, t);
    end
    for (int k = 0; k < n; k++) begin
      for (int j = 0; j < rl; j++) begin
        if (!row_set[k][j] || $urandom_range(0, 3) == 0) put_sample(k, j, rand_sample());
      end
    end
  endtask

  task automatic test_default_registers();
    put_knot(0, -65536);
    put_knot(1, 196608);
    for (int j = 0; j < 3; j++) begin
      put_sample(0, j, rand_sample());
      put_sample(1, j, rand_sample());
    end
    query(-65536);
    query(196608);
    query(65536);
    query(-65537);
    query(196609);
  endtask

  task automatic test_full_span();
    set_config(7'd2, 7'd2, 7'd0);
    put_knot(0, T_MIN);
    put_knot(1, T_MAX);
    put_sample(0, 0, T_MIN);
    put_sample(1, 0, T_MAX);
    put_sample(0, 1, T_MAX);
    put_sample(1, 1, T_MIN);
    query(T_MIN);
    query(T_MAX - 1);
    query(0);
    query(T_MAX);
    query(-1);
  endtask

  task automatic test_hold_mode();
    set_config(7'd4, 7'd3, 7'd1);
    prepare_table(1);
    repeat (3) query_inside();
    query(knot_time[1]);
    query(knot_time[3]);
  endtask

  task automatic test_unsorted_table();
    set_config(7'd4, 7'd2, 7'd0);
    put_knot(0, 0);
    put_knot(1, 1310720);
    put_knot(2, 327680);
    put_knot(3, 655360);
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 2; j++) put_sample(k, j, rand_sample());
    end
    query(655360);
    query(500000);
    put_knot(0, 655360);
    put_knot(1, 0);
    query(655360);
    query(458752);
    put_knot(3, 0);
    query(327680);
  endtask

  task automatic test_register_clamps();
    set_config(7'd127, 7'd0, 7'd0);
    prepare_table(0);
    repeat (2) query_inside();
    repeat (2) query_edge();
    set_config(7'd1, 7'd31, 7'd0);
    prepare_table(2);
    repeat (2) query_inside();
    set_config(7'd0, 7'd17, 7'd1);
    query_inside();
    quiesce();
    put_reg(CFG_UNUSED, 7'h7f);
    cfg_we <= 1'b0;
    query_inside();
    query_edge();
  endtask

  task automatic test_unused_mode();
    repeat (3) begin
      send_word(word_of(MODE_NONE, $urandom, $urandom, $urandom, $urandom));
      query_inside();
    end
  endtask

  task automatic test_output_backpressure();
    set_config(7'd3, 7'd16, 7'd0);
    prepare_table(1);
    quiesce();
    hold_off_req = 400;
    repeat (6) query_inside();
    quiesce();
  endtask

  task automatic test_random_traffic();
    int sent, phase, len, pick, kc, n, rl;
    logic [6:0] rl_data, hold_data;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      case (phase)
        0: set_config(7'd64, 7'd1, 7'd0);
        1: set_config(7'd2, 7'd16, 7'd0);
        default: begin
          case ($urandom_range(0, 5))
            0: kc = 2;
            1: kc = $urandom_range(3, 8);
            2: kc = $urandom_range(9, 64);
            3: kc = $urandom_range(0, 1);
            4: kc = $urandom_range(65, 127);
            default: kc = $urandom_range(2, 6);
          endcase
          n = (kc < 2) ? 2 : (kc > KNOTS) ? KNOTS : kc;
          rl = (n > 16) ? $urandom_range(0, 2) : $urandom_range(0, 31);
          rl_data = 7'(rl) | (7'($urandom_range(0, 3)) << 5);
          hold_data = 7'($urandom_range(0, 3) == 0) | (7'($urandom_range(0, 63)) << 1);
          set_config(7'(kc), rl_data, hold_data);
        end
      endcase
      calm = (phase == 3);
      prepare_table((phase < 2) ? 0 : $urandom_range(0, 2));
      n = knots_in_use();
      rl = row_in_use();
      len = $urandom_range(15, 35);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) query_inside();
        else if (pick < 62) query_edge();
        else if (pick < 78) put_sample($urandom_range(0, n - 1), $urandom_range(0, rl - 1),
                                       rand_sample());
        else if (pick < 86) put_sample($urandom_range(0, 63), $urandom_range(0, 15),
                                       rand_sample());
        else if (pick < 93) put_knot($urandom_range(0, 63), rand_sample());
        else send_word(word_of(MODE_NONE, $urandom, $urandom, $urandom, $urandom));
        if (pick < 93) sent++;
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_off_req > 0) begin
      hold_off_left = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (samples_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result word: elem %0d value %h last %b oor %b",
                   out_word.element_index_res, out_word.value, out_word.last,
                   out_word.out_of_range);
        end
      end else begin
        want = samples_due.pop_front();
        if (out_word.element_index_res !== want.element_index_res ||
            out_word.value !== want.value || out_word.last !== want.last ||
            out_word.out_of_range !== want.out_of_range) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected elem %0d value %h last %b oor %b, got elem %0d value %h last %b oor %b",
                     want.element_index_res, want.value, want.last, want.out_of_range,
                     out_word.element_index_res, out_word.value, out_word.last,
                     out_word.out_of_range);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_KNOT_COUNT;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_default_registers();
    test_full_span();
    test_hold_mode();
    test_unsorted_table();
    test_register_clamps();
    test_unused_mode();
    test_output_backpressure();
    test_random_traffic();
    quiesce();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && samples_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
